// File: hdl/clps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clps_pkg: shared types and constants for the character LCD sequencer
// Command codes, status codes, request kinds, init phases and bus layouts.
// ----------------------------------------------------------------------------
package clps_pkg;

  localparam int DISPLAY_COLUMNS = 16;
  localparam int DISPLAY_ROWS    = 2;

  localparam logic [7:0] SET_DDRAM_CMD = 8'h80;
  localparam logic [7:0] ROW2_OFFSET   = 8'h40;
  localparam logic [7:0] CLEAR_CMD     = 8'h01;

  localparam int CFG_COUNT = 8;
  localparam int CFG_IDX_W = $clog2(CFG_COUNT);

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_SETPOS = 2'd2,
    CMD_WRITE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_READY = 2'd1,
    ST_RANGE     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_CLEAR  = 2'd1,
    KIND_SETPOS = 2'd2,
    KIND_WRITE  = 2'd3
  } kind_t;

  typedef enum logic [5:0] {
    PH_POWER = 6'b000001,
    PH_FUNC  = 6'b000010,
    PH_ENTRY = 6'b000100,
    PH_DISP  = 6'b001000,
    PH_END   = 6'b010000,
    PH_OPER  = 6'b100000
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EIGHT_BIT_BUS    = 3'd0,
    CFG_TWO_LINE_MODE    = 3'd1,
    CFG_LARGE_FONT       = 3'd2,
    CFG_CURSOR_INCREMENT = 3'd3,
    CFG_DISPLAY_SHIFT    = 3'd4,
    CFG_DISPLAY_ON       = 3'd5,
    CFG_CURSOR_VISIBLE   = 3'd6,
    CFG_CURSOR_BLINK     = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic eight_bit_bus;
    logic two_line_mode;
    logic large_font;
    logic cursor_increment;
    logic display_shift;
    logic display_on;
    logic cursor_visible;
    logic cursor_blink;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    eight_bit_bus:    1'b1,
    two_line_mode:    1'b1,
    large_font:       1'b0,
    cursor_increment: 1'b1,
    display_shift:    1'b0,
    display_on:       1'b1,
    cursor_visible:   1'b0,
    cursor_blink:     1'b0
  };

  // request payload, lowest field last in the struct
  typedef struct packed {
    logic [7:0] character;
    logic [4:0] column;
    logic [1:0] row;
  } req_t;

  // result payload, lowest field last in the struct
  typedef struct packed {
    logic       enable_pin;
    logic [7:0] data_bus;
    logic       read_write;
    logic       reg_select;
    logic       ready_res;
    logic [1:0] status;
  } res_t;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

endpackage

// File: hdl/clps_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clps_core: LCD sequencer state and per-item update
// Holds the config bits, init phase, strobe phase, pending request and pin
// levels; computes the result of one item and commits it on step.
// ----------------------------------------------------------------------------
module clps_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [clps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                          cfg_data,
  input  logic                          step,
  input  clps_pkg::cmd_t                cmd,
  input  clps_pkg::req_t                req,
  output clps_pkg::res_t                res
);

  clps_pkg::cfg_t    cfg;
  clps_pkg::phase_t  phase, phase_next;
  logic              strobe_phase, strobe_phase_next;
  clps_pkg::kind_t   kind, kind_next;
  logic [7:0]        pend_byte, pend_byte_next;
  logic              pin_rs, pin_rs_next;
  logic              pin_en, pin_en_next;
  logic [7:0]        pin_data, pin_data_next;

  clps_pkg::status_t status;
  logic              ready;
  logic              out_of_range;
  logic              do_strobe;
  logic              strobe_rs;
  logic [7:0]        strobe_byte;
  logic [7:0]        init_byte;
  logic [7:0]        setpos_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= clps_pkg::CFG_RESET;
    end else if (cfg_we) begin
      case (clps_pkg::cfg_idx_t'(cfg_index))
        clps_pkg::CFG_EIGHT_BIT_BUS:    cfg.eight_bit_bus    <= cfg_data;
        clps_pkg::CFG_TWO_LINE_MODE:    cfg.two_line_mode    <= cfg_data;
        clps_pkg::CFG_LARGE_FONT:       cfg.large_font       <= cfg_data;
        clps_pkg::CFG_CURSOR_INCREMENT: cfg.cursor_increment <= cfg_data;
        clps_pkg::CFG_DISPLAY_SHIFT:    cfg.display_shift    <= cfg_data;
        clps_pkg::CFG_DISPLAY_ON:       cfg.display_on       <= cfg_data;
        clps_pkg::CFG_CURSOR_VISIBLE:   cfg.cursor_visible   <= cfg_data;
        clps_pkg::CFG_CURSOR_BLINK:     cfg.cursor_blink     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (phase)
      clps_pkg::PH_FUNC:  init_byte = {3'b001, cfg.eight_bit_bus, cfg.two_line_mode,
                                       cfg.large_font, 2'b00};
      clps_pkg::PH_ENTRY: init_byte = {6'b000001, cfg.cursor_increment, cfg.display_shift};
      default:            init_byte = {5'b00001, cfg.display_on, cfg.cursor_visible,
                                       cfg.cursor_blink};
    endcase
  end

  assign ready        = (phase == clps_pkg::PH_OPER) && (kind == clps_pkg::KIND_NONE);
  assign out_of_range = (req.row == 2'd0) || (32'(req.row) > clps_pkg::DISPLAY_ROWS) ||
                        (req.column == 5'd0) ||
                        (32'(req.column) > clps_pkg::DISPLAY_COLUMNS);
  assign setpos_byte  = clps_pkg::SET_DDRAM_CMD +
                        ((req.row == 2'd2) ? clps_pkg::ROW2_OFFSET : 8'h00) +
                        {3'b000, req.column} - 8'd1;

  always_comb begin
    phase_next        = phase;
    strobe_phase_next = strobe_phase;
    kind_next         = kind;
    pend_byte_next    = pend_byte;
    pin_rs_next       = pin_rs;
    pin_en_next       = pin_en;
    pin_data_next     = pin_data;
    status            = clps_pkg::ST_OK;
    do_strobe         = 1'b0;
    strobe_rs         = 1'b0;
    strobe_byte       = init_byte;

    case (cmd)
      clps_pkg::CMD_TICK: begin
        case (phase)
          clps_pkg::PH_POWER: phase_next = clps_pkg::PH_FUNC;
          clps_pkg::PH_FUNC: begin
            do_strobe = 1'b1;
            if (strobe_phase) phase_next = clps_pkg::PH_ENTRY;
          end
          clps_pkg::PH_ENTRY: begin
            do_strobe = 1'b1;
            if (strobe_phase) phase_next = clps_pkg::PH_DISP;
          end
          clps_pkg::PH_DISP: begin
            do_strobe = 1'b1;
            if (strobe_phase) phase_next = clps_pkg::PH_END;
          end
          clps_pkg::PH_OPER: begin
            if (kind != clps_pkg::KIND_NONE) begin
              do_strobe   = 1'b1;
              strobe_rs   = (kind == clps_pkg::KIND_WRITE);
              strobe_byte = pend_byte;
              if (strobe_phase) kind_next = clps_pkg::KIND_NONE;
            end
          end
          default: phase_next = clps_pkg::PH_OPER;
        endcase
      end
      clps_pkg::CMD_SETPOS: begin
        if (out_of_range) begin
          status = clps_pkg::ST_RANGE;
        end else if (!ready) begin
          status = clps_pkg::ST_NOT_READY;
        end else begin
          pend_byte_next = setpos_byte;
          kind_next      = clps_pkg::KIND_SETPOS;
        end
      end
      clps_pkg::CMD_CLEAR: begin
        if (!ready) begin
          status = clps_pkg::ST_NOT_READY;
        end else begin
          pend_byte_next = clps_pkg::CLEAR_CMD;
          kind_next      = clps_pkg::KIND_CLEAR;
        end
      end
      default: begin
        if (!ready) begin
          status = clps_pkg::ST_NOT_READY;
        end else begin
          pend_byte_next = req.character;
          kind_next      = clps_pkg::KIND_WRITE;
        end
      end
    endcase

    if (do_strobe) begin
      if (!strobe_phase) begin
        pin_rs_next       = strobe_rs;
        pin_en_next       = 1'b1;
        pin_data_next     = strobe_byte;
        strobe_phase_next = 1'b1;
      end else begin
        pin_en_next       = 1'b0;
        strobe_phase_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= clps_pkg::PH_POWER;
      strobe_phase <= 1'b0;
      kind         <= clps_pkg::KIND_NONE;
      pend_byte    <= 8'h00;
      pin_rs       <= 1'b0;
      pin_en       <= 1'b0;
      pin_data     <= 8'h00;
    end else if (step) begin
      phase        <= phase_next;
      strobe_phase <= strobe_phase_next;
      kind         <= kind_next;
      pend_byte    <= pend_byte_next;
      pin_rs       <= pin_rs_next;
      pin_en       <= pin_en_next;
      pin_data     <= pin_data_next;
    end
  end

  always_comb begin
    res.status     = status;
    res.ready_res  = (phase_next == clps_pkg::PH_OPER) && (kind_next == clps_pkg::KIND_NONE);
    res.reg_select = pin_rs_next;
    res.read_write = 1'b0;
    res.data_bus   = pin_data_next;
    res.enable_pin = pin_en_next;
  end

endmodule

// File: hdl/char_lcd_parallel_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_parallel_sequencer: tick-driven 8-bit character LCD controller
//
//   channel  dir  transfer when           payload
//   s_axis   in   s_tvalid & s_tready     tuser: cmd; tdata: row, column, char
//   m_axis   out  m_tvalid & m_tready     tdata: status, ready, pins
//   cfg      in   cfg_we                  cfg_index, cfg_data
//
// One item per cycle: the update is one combinational pass from the state
// registers into the output register. A two-entry output buffer (output
// register plus skid) lets input transfers continue while a result waits;
// s_tready drops only once both entries are full. Reset (rst, synchronous)
// returns to the power-on init step with default config.
// ----------------------------------------------------------------------------
module char_lcd_parallel_sequencer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [clps_pkg::IN_DATA_W-1:0]      s_tdata,   // row[1:0], column[6:2], character[14:7]
  input  logic [1:0]                          s_tuser,   // cmd[1:0]
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [clps_pkg::OUT_DATA_W-1:0]     m_tdata,   // status[1:0], ready_res[2],
                                                         // reg_select[3], read_write[4],
                                                         // data_bus[12:5], enable_pin[13]
  input  logic                                cfg_we,
  input  logic [clps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic                                cfg_data
);

  logic            s_xfer;
  logic            drain;
  clps_pkg::res_t  res;
  clps_pkg::res_t  out_data, skid_data;
  logic            out_valid, skid_valid;

  assign s_tready = !skid_valid;
  assign s_xfer   = s_tvalid && s_tready;
  assign drain    = out_valid && m_tready;

  clps_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (s_xfer),
    .cmd       (clps_pkg::cmd_t'(s_tuser)),
    .req       (clps_pkg::req_t'(s_tdata[$bits(clps_pkg::req_t)-1:0])),
    .res       (res)
  );

  // a full skid entry holds s_tready low, so it never meets an input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (drain && skid_valid) begin
      out_data   <= skid_data;
      skid_valid <= 1'b0;
    end else if (s_xfer && (!out_valid || drain)) begin
      out_data  <= res;
      out_valid <= 1'b1;
    end else if (s_xfer) begin
      skid_data  <= res;
      skid_valid <= 1'b1;
    end else if (drain) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(clps_pkg::OUT_DATA_W - $bits(clps_pkg::res_t)){1'b0}}, out_data};

  // skid entry is only used behind a held output entry
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> out_valid)
    else $error("skid entry valid without output entry");

  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !m_tvalid) |=> m_tvalid)
    else $error("accepted item did not reach the output register");

  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && m_tvalid && !m_tready) |=> skid_valid)
    else $error("stalled result not parked in skid entry");

endmodule
